### rtl/gabor_window_convolution_core_defines.svh
// assertion helpers used by gabor_window_convolution_core
`ifndef GABOR_WINDOW_CONVOLUTION_CORE_DEFINES_SVH
`define GABOR_WINDOW_CONVOLUTION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define GWC_ASSERT_SAME(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("gwc assertion failed");
`define GWC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("gwc assertion failed");
`else
`define GWC_ASSERT_SAME(lbl, clk, rst_n, a, b)
`define GWC_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

### rtl/gwc_pkg.sv
package gwc_pkg;

    localparam int TAB_FRAC = 15;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAG_MAX = 1023;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DIRECTION = 2'd2;

    typedef struct packed {
        logic produce;
        logic row_end;
        logic frame_end;
    } gwc_ctl_t;

    localparam int AXIS_TAB [4][4] = '{
        '{0, 0, 0, 0},
        '{496, 494, 486, 474},
        '{889, 885, 871, 850},
        '{1107, 1102, 1085, 1058}};

    localparam int DIAG_TAB [7][7] = '{
        '{0, 0, 0, 0, 0, 0, 0},
        '{0, 356, 0, 349, 0, 336, 0},
        '{677, 0, 670, 0, 650, 0, 0},
        '{0, 923, 0, 905, 0, 0, 0},
        '{1084, 0, 1073, 0, 0, 0, 0},
        '{0, 1140, 0, 0, 0, 0, 0},
        '{1111, 0, 0, 0, 0, 0, 0}};

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int from_axis(input int a, input int b);
        int m;
        m = AXIS_TAB[iabs(a) & 3][iabs(b) & 3];
        return (a < 0) ? -m : m;
    endfunction

    function automatic int from_diag(input int a, input int b);
        int m;
        m = 0;
        if (iabs(a) <= 6 && iabs(b) <= 6)
        begin
            m = DIAG_TAB[iabs(a)][iabs(b)];
        end
        return (a < 0) ? -m : m;
    endfunction

    // q1.15 coefficient for row offset k, column offset l
    function automatic int coef_q15(input logic [3:0] dir, input int k, input int l);
        int v;
        v = 0;
        if (iabs(k) <= 3 && iabs(l) <= 3)
        begin
            unique case (dir[2:0])
                3'd1: v = from_diag(k + l, l - k);
                3'd2: v = from_axis(l, k);
                3'd3: v = from_diag(l - k, k + l);
                3'd4: v = -from_axis(k, l);
                3'd5: v = -from_diag(k + l, l - k);
                3'd6: v = -from_axis(l, k);
                3'd7: v = -from_diag(l - k, k + l);
                3'd0: v = from_axis(k, l);
            endcase
        end
        return v;
    endfunction

    // bring a q1.15 value to frac fraction bits, rounding half away from zero
    function automatic int scale_coef(input int v, input int frac);
        int m;
        m = iabs(v);
        if (frac >= TAB_FRAC)
        begin
            m = m <<< (frac - TAB_FRAC);
        end
        else
        begin
            m = (m + (1 <<< (TAB_FRAC - frac - 1))) >>> (TAB_FRAC - frac);
        end
        return (v < 0) ? -m : m;
    endfunction

endpackage

### rtl/gwc_if.sv
interface gwc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface gwc_res_if;
    logic       valid;
    logic       ready;
    logic [9:0] magnitude;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output magnitude, output row_end, output frame_end,
                    input ready);
    modport sink (input valid, input magnitude, input row_end, input frame_end,
                  output ready);
endinterface

interface gwc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/gabor_window_convolution_core.sv
// path: a result passes the stage a, w and p registers and then the output register
// throughput: one pixel per cycle while not stalled, set by the single line-store port pair
// (one read and one write of a packed column every cycle)
// stalls only while the output word is held and not taken
// reset: counters at zero, registers 640 / 480 / 1, pipeline empty;
// line store is not cleared and needs no clearing pass
`include "gabor_window_convolution_core_defines.svh"

module gabor_window_convolution_core #(
    parameter int MAX_WIDTH = 1024,
    parameter int HALF_ROWS = 3,
    parameter int HALF_COLS = 3,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    gwc_pix_if.sink       pix_in,
    gwc_res_if.source     res_out,
    gwc_cfg_if.sink       cfg
);
    import gwc_pkg::*;

    localparam int WIN_R = 2 * HALF_ROWS + 1;
    localparam int WIN_C = 2 * HALF_COLS + 1;
    localparam int LINES = 2 * HALF_ROWS;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int COEF_W = 12 + ((COEF_FRAC_BITS > TAB_FRAC) ? COEF_FRAC_BITS - TAB_FRAC : 0);
    localparam int PART_W = PIXEL_BITS + 1 + COEF_W + $clog2(WIN_R);

    // configuration
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [3:0]  dir_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd640;
            height_reg <= 13'd480;
            dir_reg <= 4'd1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_WIDTH:     width_reg <= cfg.data[10:0];
                REG_HEIGHT:    height_reg <= cfg.data;
                REG_DIRECTION: dir_reg <= cfg.data[3:0];
                default:       ;
            endcase
        end
    end

    logic [COL_W-1:0] w_last;
    logic [11:0]      h_last;

    always_comb
    begin
        if (width_reg < 11'(WIN_C))
        begin
            w_last = COL_W'(WIN_C - 1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = COL_W'(width_reg - 11'd1);
        end
        if (height_reg < 13'(WIN_R))
        begin
            h_last = 12'(WIN_R - 1);
        end
        else if (height_reg > 13'(MAX_HEIGHT))
        begin
            h_last = 12'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_last = 12'(height_reg - 13'd1);
        end
    end

    // pipeline control
    logic advance;
    logic in_accept;
    logic out_valid;

    assign advance = !out_valid || res_out.ready;
    assign pix_in.ready = advance;
    assign in_accept = pix_in.valid && advance;

    // position counters
    logic [COL_W-1:0] col_reg, col_next, c;
    logic [11:0]      row_reg, row_next, r;
    gwc_ctl_t         ctl_now;

    always_comb
    begin
        c = pix_in.frame_start ? '0 : col_reg;
        r = pix_in.frame_start ? '0 : row_reg;
        ctl_now.row_end = (c >= w_last);
        ctl_now.produce = (32'(r) >= LINES) && (32'(c) >= WIN_C - 1);
        ctl_now.frame_end = ctl_now.row_end && (r >= h_last);
        if (ctl_now.row_end)
        begin
            col_next = '0;
            row_next = (r >= h_last) ? 12'd0 : r + 12'd1;
        end
        else
        begin
            col_next = c + 1'b1;
            row_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage a: pixel registered, line store read word registered alongside it
    logic                  a_v_reg, w_v_reg, p_v_reg;
    logic [PIXEL_BITS-1:0] a_px_reg;
    logic [COL_W-1:0]      a_col_reg;
    gwc_ctl_t              a_ctl_reg, w_ctl_reg, p_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            w_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_v_reg <= pix_in.valid;
            w_v_reg <= a_v_reg && a_ctl_reg.produce;
            p_v_reg <= w_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_px_reg <= PIXEL_BITS'(pix_in.pixel);
            a_col_reg <= c;
            a_ctl_reg <= ctl_now;
        end
        if (advance)
        begin
            w_ctl_reg <= a_ctl_reg;
            p_ctl_reg <= w_ctl_reg;
        end
    end

    logic [LINES*PIXEL_BITS-1:0] lines_q;
    logic [WIN_R*PIXEL_BITS-1:0] new_col;
    logic                        shift_en;

    assign shift_en = a_v_reg && advance;
    assign new_col = {a_px_reg, lines_q};

    gwc_line_buf #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LINES * PIXEL_BITS)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (c),
        .wr_en   (shift_en),
        .wr_addr (a_col_reg),
        .wr_data (new_col[WIN_R*PIXEL_BITS-1:PIXEL_BITS]),
        .rd_data (lines_q)
    );

    // window columns, oldest in cell 0
    logic [WIN_R*PIXEL_BITS-1:0] cols [WIN_C];
    logic signed [PART_W-1:0]    parts [WIN_C];

    for (genvar j = 0; j < WIN_C; j++)
    begin : g_cell
        gwc_cell #(
            .COL            (j),
            .HALF_ROWS      (HALF_ROWS),
            .HALF_COLS      (HALF_COLS),
            .PIXEL_BITS     (PIXEL_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS),
            .PART_W         (PART_W)
        ) u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .load_en  (advance),
            .dir      (dir_reg),
            .col_in   ((j == WIN_C - 1) ? new_col : cols[(j + 1) % WIN_C]),
            .col_out  (cols[j]),
            .part     (parts[j])
        );
    end

    gwc_ctl_t out_ctl;

    gwc_reduce #(
        .WIN_C          (WIN_C),
        .PART_W         (PART_W),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (p_v_reg),
        .in_ctl    (p_ctl_reg),
        .part      (parts),
        .out_valid (out_valid),
        .magnitude (res_out.magnitude),
        .out_ctl   (out_ctl)
    );

    assign res_out.valid = out_valid;
    assign res_out.row_end = out_ctl.row_end;
    assign res_out.frame_end = out_ctl.frame_end;

    `GWC_ASSERT_NEXT(a_row_wrap, clk, rst_n, in_accept && ctl_now.row_end, col_reg == '0)
    `GWC_ASSERT_SAME(a_window_from_pixel, clk, rst_n, $rose(w_v_reg), $past(a_v_reg))
    `GWC_ASSERT_SAME(a_out_from_part, clk, rst_n, $rose(out_valid), $past(p_v_reg))
    `GWC_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance, $stable(a_col_reg) && $stable(p_v_reg))
endmodule

### rtl/gwc_line_buf.sv
module gwc_line_buf #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a write landing on the address being read forwards its word
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && wr_addr == rd_addr)
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### rtl/gwc_cell.sv
module gwc_cell #(
    parameter int COL = 0,
    parameter int HALF_ROWS = 3,
    parameter int HALF_COLS = 3,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_FRAC_BITS = 15,
    parameter int PART_W = 24
) (
    input  logic                                    clk,
    input  logic                                    shift_en,
    input  logic                                    load_en,
    input  logic [3:0]                              dir,
    input  logic [(2*HALF_ROWS+1)*PIXEL_BITS-1:0]   col_in,
    output logic [(2*HALF_ROWS+1)*PIXEL_BITS-1:0]   col_out,
    output logic signed [PART_W-1:0]                part
);
    import gwc_pkg::*;

    localparam int WIN_R = 2 * HALF_ROWS + 1;
    localparam int COEF_W = 12 + ((COEF_FRAC_BITS > TAB_FRAC) ? COEF_FRAC_BITS - TAB_FRAC : 0);

    logic [WIN_R*PIXEL_BITS-1:0] col_reg;
    logic signed [PART_W-1:0]    part_reg;
    logic signed [PART_W-1:0]    part_next;
    logic signed [COEF_W-1:0]    coef [WIN_R];

    for (genvar i = 0; i < WIN_R; i++)
    begin : g_coef
        assign coef[i] = COEF_W'(scale_coef(coef_q15(dir, HALF_ROWS - i, HALF_COLS - COL),
                                            COEF_FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    always_comb
    begin
        part_next = '0;
        for (int i = 0; i < WIN_R; i++)
        begin
            part_next = part_next + PART_W'(
                $signed({1'b0, col_reg[i*PIXEL_BITS +: PIXEL_BITS]}) * coef[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            part_reg <= part_next;
        end
    end

    assign col_out = col_reg;
    assign part = part_reg;
endmodule

### rtl/gwc_reduce.sv
module gwc_reduce #(
    parameter int WIN_C = 7,
    parameter int PART_W = 24,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  gwc_pkg::gwc_ctl_t        in_ctl,
    input  logic signed [PART_W-1:0] part [WIN_C],
    output logic                     out_valid,
    output logic [9:0]               magnitude,
    output gwc_pkg::gwc_ctl_t        out_ctl
);
    import gwc_pkg::*;

    localparam int SUM_W = PART_W + $clog2(WIN_C);

    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        abs_sum;
    logic [SUM_W-1:0]        shifted;
    logic [9:0]              mag_next;
    logic                    valid_reg;
    logic [9:0]              mag_reg;
    gwc_ctl_t                ctl_reg;

    always_comb
    begin
        sum = '0;
        for (int j = 0; j < WIN_C; j++)
        begin
            sum = sum + SUM_W'(part[j]);
        end
        abs_sum = (sum < 0) ? SUM_W'(-sum) : SUM_W'(sum);
        shifted = abs_sum >> COEF_FRAC_BITS;
        mag_next = (shifted > SUM_W'(MAG_MAX)) ? 10'(MAG_MAX) : 10'(shifted);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg <= mag_next;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid = valid_reg;
    assign magnitude = mag_reg;
    assign out_ctl = ctl_reg;
endmodule
